[rtl/sse_pkg.sv]
`default_nettype none
package sse_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int RUNE_W = 21;
  localparam int OFFS_W = 16;
  localparam int MODE_W = 2;

  typedef logic [RUNE_W-1:0] rune_t;
  typedef logic [OFFS_W-1:0] offs_t;

  // search_mode codes; the unused code behaves as contains
  localparam logic [MODE_W-1:0] MODE_CONTAINS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUFFIX   = 2'd2;

  // in_tuser codes
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // per-cell compare status, cells past the pattern length report a match
  typedef struct packed {
    logic eq_now;    // stored window rune vs pattern rune
    logic eq_shift;  // incoming window rune vs pattern rune
  } cell_eq_t;

endpackage
`default_nettype wire

[rtl/sse_cell.sv]
`default_nettype none
module sse_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 5
) (
  input  wire logic                clk,
  input  wire logic                text_shift,
  input  wire logic                pat_shift,
  input  wire sse_pkg::rune_t      text_in,
  input  wire sse_pkg::rune_t      pat_in,
  input  wire logic [LEN_W-1:0]    pat_len,
  output sse_pkg::rune_t           text_out,
  output sse_pkg::rune_t           pat_out,
  output sse_pkg::cell_eq_t        status
);

  sse_pkg::rune_t win_r;
  sse_pkg::rune_t pat_r;
  logic           active;

  // pat_r holds the pattern reversed: cell k sees pattern[len-1-k]
  always_ff @(posedge clk) begin
    if (text_shift) begin
      win_r <= text_in;
    end
    if (pat_shift) begin
      pat_r <= pat_in;
    end
  end

  assign active = pat_len > LEN_W'(IDX);

  always_comb begin
    status.eq_now   = !active || (win_r == pat_r);
    status.eq_shift = !active || (text_in == pat_r);
  end

  assign text_out = win_r;
  assign pat_out  = pat_r;

endmodule
`default_nettype wire

[rtl/substring_search_engine.sv]
`default_nettype none
// Streaming substring search. Load a pattern first as pattern beats (in_tuser = 0), closed by
// in_tlast; then stream the text as text beats (in_tuser = 1). The beat with in_tlast on the
// text returns one result beat: found, match offset and overflow, as selected by search_mode
// (0 contains / first index, 1 starts with, 2 ends with; 3 acts as 0). An empty pattern always
// matches at offset 0. Pattern runes past MAX_PATTERN are dropped; text past MAX_TEXT runes is
// dropped and flagged as overflow. Each accepted beat is handled at once: the text window
// shifts through a row of MAX_PATTERN cells that each compare one window rune with one pattern
// rune, and their flags are ANDed in the same cycle. The result sits in an output register;
// while it waits untaken, in_tready is low and all input beats stall until out_tready takes
// it. in_tready is also low during reset.
module substring_search_engine #(
  parameter int MAX_PATTERN = sse_pkg::MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = sse_pkg::MAX_TEXT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,    // search_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,     // rune_value[20:0], is_empty[21], zero pad
  input  wire logic        in_tuser,     // req_type
  input  wire logic        in_tlast,     // last_rune
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata     // found[0], match_offset[16:1], overflow[17], zero pad
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int PW = $clog2(MAX_TEXT + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW = (PW > LW) ? PW : LW;

  // control state
  logic [sse_pkg::MODE_W-1:0] mode_r;
  logic [LW-1:0]              plen_r, plen_nxt;
  logic                       closed_r, closed_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic                       seen_r, seen_nxt;
  sse_pkg::offs_t             first_r, first_nxt;
  logic                       pfail_r, pfail_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       res_found_r;
  sse_pkg::offs_t             res_offs_r;
  logic                       res_ovf_r;

  // forward copy of the pattern, read at the text position for the prefix check
  sse_pkg::rune_t             pat_mem [2**IW];
  sse_pkg::rune_t             pat_rd_r;

  // beat decode
  logic                       acc, is_pat, is_txt, empty, res_now;
  sse_pkg::rune_t             rune;
  logic [LW-1:0]              plen_base;
  logic                       pat_shift, txt_shift, txt_room;
  logic [PW-1:0]              pos_e;
  logic [CW-1:0]              pos_x, pos_e_x, plen_x, diff, pos_nxt_x;
  logic                       pfail_e, match_e, new_hit, seen_e, ovf_e;
  sse_pkg::offs_t             first_e;
  logic                       all_now, all_shift;
  logic                       found_c;
  sse_pkg::offs_t             offs_c;

  // cell row
  sse_pkg::rune_t             win_q   [MAX_PATTERN];
  sse_pkg::rune_t             prv_q   [MAX_PATTERN];
  sse_pkg::cell_eq_t          cell_st [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     eq_now_v, eq_shift_v;

  assign acc    = in_tvalid && in_tready;
  assign is_pat = acc && (in_tuser == sse_pkg::REQ_PATTERN);
  assign is_txt = acc && (in_tuser == sse_pkg::REQ_TEXT);
  assign rune   = in_tdata[sse_pkg::RUNE_W-1:0];
  assign empty  = in_tdata[sse_pkg::RUNE_W];

  assign in_tready = rst_n && (!out_valid_r || out_tready);

  assign plen_base = closed_r ? '0 : plen_r;
  assign pat_shift = is_pat && !empty && (plen_base < LW'(MAX_PATTERN));
  assign txt_room  = pos_r < PW'(MAX_TEXT);
  assign txt_shift = is_txt && !empty && txt_room;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      sse_pkg::rune_t t_in, p_in;
      if (k == 0) begin : g_head
        assign t_in = rune;
        assign p_in = rune;
      end else begin : g_body
        assign t_in = win_q[k-1];
        assign p_in = prv_q[k-1];
      end
      sse_cell #(
        .IDX   (k),
        .LEN_W (LW)
      ) u_cell (
        .clk        (clk),
        .text_shift (txt_shift),
        .pat_shift  (pat_shift),
        .text_in    (t_in),
        .pat_in     (p_in),
        .pat_len    (plen_r),
        .text_out   (win_q[k]),
        .pat_out    (prv_q[k]),
        .status     (cell_st[k])
      );
      assign eq_now_v[k]   = cell_st[k].eq_now;
      assign eq_shift_v[k] = cell_st[k].eq_shift;
    end
  endgenerate

  assign all_now   = &eq_now_v;
  assign all_shift = &eq_shift_v;

  // text step
  always_comb begin
    pos_e    = txt_shift ? (pos_r + PW'(1)) : pos_r;
    pos_x    = CW'(pos_r);
    pos_e_x  = CW'(pos_e);
    plen_x   = CW'(plen_r);
    diff     = pos_e_x - plen_x;
    pfail_e  = pfail_r || (txt_shift && (pos_x < plen_x) && (pat_rd_r != rune));
    match_e  = (plen_r != '0) && (pos_e_x >= plen_x) && (txt_shift ? all_shift : all_now);
    new_hit  = txt_shift && !seen_r && match_e;
    seen_e   = seen_r || new_hit;
    first_e  = new_hit ? sse_pkg::OFFS_W'(diff) : first_r;
    ovf_e    = ovf_r || (is_txt && !empty && !txt_room);
    res_now  = is_txt && in_tlast;
  end

  // result select
  always_comb begin
    found_c = 1'b0;
    offs_c  = '0;
    if (plen_r == '0) begin
      found_c = 1'b1;
    end else begin
      case (mode_r)
        sse_pkg::MODE_PREFIX: begin
          found_c = (pos_e_x >= plen_x) && !pfail_e;
        end
        sse_pkg::MODE_SUFFIX: begin
          found_c = match_e;
          offs_c  = match_e ? sse_pkg::OFFS_W'(diff) : '0;
        end
        default: begin
          found_c = seen_e;
          offs_c  = seen_e ? first_e : '0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    plen_nxt      = plen_r;
    closed_nxt    = closed_r;
    pos_nxt       = pos_r;
    seen_nxt      = seen_r;
    first_nxt     = first_r;
    pfail_nxt     = pfail_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (is_pat) begin
      closed_nxt = in_tlast;
      if (empty) begin
        plen_nxt = '0;
      end else if (pat_shift) begin
        plen_nxt = plen_base + LW'(1);
      end else begin
        plen_nxt = plen_base;
      end
    end
    if (is_txt) begin
      if (res_now) begin
        pos_nxt       = '0;
        seen_nxt      = 1'b0;
        first_nxt     = '0;
        pfail_nxt     = 1'b0;
        ovf_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        pos_nxt   = pos_e;
        seen_nxt  = seen_e;
        first_nxt = first_e;
        pfail_nxt = pfail_e;
        ovf_nxt   = ovf_e;
      end
    end
    pos_nxt_x = CW'(pos_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= sse_pkg::MODE_CONTAINS;
      plen_r      <= '0;
      closed_r    <= 1'b0;
      pos_r       <= '0;
      seen_r      <= 1'b0;
      first_r     <= '0;
      pfail_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      plen_r      <= plen_nxt;
      closed_r    <= closed_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      first_r     <= first_nxt;
      pfail_r     <= pfail_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_now) begin
      res_found_r <= found_c;
      res_offs_r  <= offs_c;
      res_ovf_r   <= ovf_e;
    end
  end

  // read port prefetches the entry at the next text position; write-first bypass
  always_ff @(posedge clk) begin
    if (pat_shift) begin
      pat_mem[plen_base[IW-1:0]] <= rune;
    end
    if (pat_shift && (plen_base[IW-1:0] == pos_nxt_x[IW-1:0])) begin
      pat_rd_r <= rune;
    end else begin
      pat_rd_r <= pat_mem[pos_nxt_x[IW-1:0]];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_ovf_r, res_offs_r, res_found_r};

endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAT_MAX = sse_pkg::MAX_PATTERN_DEF;
  localparam int TEXT_MAX = sse_pkg::MAX_TEXT_DEF;
  localparam logic [sse_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;  // decodes as contains
  localparam sse_pkg::rune_t RUNE_TOP = 21'h10FFFF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic           found;
    sse_pkg::offs_t offset;
    logic           overflow;
  } search_result_t;

  // Tracks pattern, text window and all three searches; forms one result per closed text.
  class substring_checker;
    logic [sse_pkg::MODE_W-1:0] mode = sse_pkg::MODE_CONTAINS;
    sse_pkg::rune_t pat[PAT_MAX];
    int unsigned pat_len = 0;
    bit pat_closed = 0;
    sse_pkg::rune_t win[PAT_MAX] = '{default: '0};
    int unsigned text_pos = 0;
    bit match_seen = 0;
    int unsigned first_off = 0;
    bit prefix_bad = 0;
    bit text_ovf = 0;
    search_result_t pending_results[$];
    int errors = 0;

    // newest pat_len window runes equal the pattern
    function bit window_hit();
      if (pat_len == 0 || text_pos < pat_len) return 0;
      for (int unsigned j = 0; j < pat_len; j++)
        if (win[pat_len-1-j] != pat[j]) return 0;
      return 1;
    endfunction

    function void take_beat(logic kind, sse_pkg::rune_t rune, logic empty, logic last);
      search_result_t res;
      if (kind == sse_pkg::REQ_PATTERN) begin
        if (pat_closed) begin
          pat_len = 0;
          pat_closed = 0;
        end
        if (empty) begin
          pat_len = 0;
        end else if (pat_len < PAT_MAX) begin
          pat[pat_len] = rune;
          pat_len++;
        end
        if (last) pat_closed = 1;
        return;
      end
      if (!empty) begin
        if (text_pos >= TEXT_MAX) begin
          text_ovf = 1;
        end else begin
          if (text_pos < pat_len && pat[text_pos] != rune) prefix_bad = 1;
          for (int i = PAT_MAX - 1; i > 0; i--) win[i] = win[i-1];
          win[0] = rune;
          text_pos++;
          if (!match_seen && window_hit()) begin
            match_seen = 1;
            first_off = text_pos - pat_len;
          end
        end
      end
      if (!last) return;
      res = '0;
      if (pat_len == 0) begin
        res.found = 1'b1;
      end else begin
        case (mode)
          sse_pkg::MODE_PREFIX: res.found = (text_pos >= pat_len) && !prefix_bad;
          sse_pkg::MODE_SUFFIX: begin
            if (window_hit()) begin
              res.found = 1'b1;
              res.offset = sse_pkg::offs_t'(text_pos - pat_len);
            end
          end
          default: begin
            if (match_seen) begin
              res.found = 1'b1;
              res.offset = sse_pkg::offs_t'(first_off);
            end
          end
        endcase
      end
      res.overflow = text_ovf;
      pending_results.push_back(res);
      win = '{default: '0};
      text_pos = 0;
      match_seen = 0;
      first_off = 0;
      prefix_bad = 0;
      text_ovf = 0;
    endfunction

    function void check_result(logic [23:0] beat);
      search_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat %h with nothing expected", $time, beat);
        return;
      end
      want = pending_results.pop_front();
      if (beat[0] !== want.found) begin
        errors++;
        $display("%0t: found expected %0b, got %0b", $time, want.found, beat[0]);
      end
      if (beat[16:1] !== want.offset) begin
        errors++;
        $display("%0t: match_offset expected %0d, got %0d", $time, want.offset, beat[16:1]);
      end
      if (beat[17] !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b, got %0b", $time, want.overflow, beat[17]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;   // rune_value[20:0], is_empty[21], zero pad
  logic in_tuser;          // req_type
  logic in_tlast;          // last_rune
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;  // found[0], match_offset[16:1], overflow[17], zero pad

  substring_checker sb = new;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int unsigned cycle_count = 0;

  substring_search_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(logic kind, sse_pkg::rune_t rune, logic empty, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tlast <= last;
    in_tdata <= {2'b00, empty, rune};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_beat(kind, rune, empty, last);
    @(negedge clk);
  endtask

  // drain, give the pipe time to settle, then write search_mode
  task automatic write_mode(logic [sse_pkg::MODE_W-1:0] m);
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    sb.mode = m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int unsigned n_beats);
    sse_pkg::rune_t pat[$];
    sse_pkg::rune_t txt[$];
    sse_pkg::rune_t base;
    int unsigned plen;
    int unsigned tlen;
    int unsigned pos;
    int unsigned sent;
    int r;
    sent = 0;
    while (sent < n_beats) begin
      r = $urandom_range(99);
      if (r < 80) begin
        // pattern then text over a tiny alphabet so hits are common
        base = sse_pkg::rune_t'($urandom_range(1114109));
        pat.delete();
        txt.delete();
        r = $urandom_range(99);
        plen = (r < 8) ? 0 : (r < 85) ? $urandom_range(4, 1) : $urandom_range(20, 5);
        for (int unsigned i = 0; i < plen; i++)
          pat.push_back(base + sse_pkg::rune_t'($urandom_range(2)));
        if (plen == 0) begin
          send_beat(sse_pkg::REQ_PATTERN, sse_pkg::rune_t'($urandom_range(1114111)), 1'b1,
                    1'b1);
          sent++;
        end else begin
          foreach (pat[i]) send_beat(sse_pkg::REQ_PATTERN, pat[i], 1'b0, i == plen - 1);
          sent += plen;
        end
        tlen = ($urandom_range(99) < 6) ? 0 : $urandom_range(24);
        for (int unsigned i = 0; i < tlen; i++)
          txt.push_back(base + sse_pkg::rune_t'($urandom_range(2)));
        if (plen > 0 && tlen >= plen && $urandom_range(1)) begin
          r = $urandom_range(2);
          pos = (r == 0) ? 0 : (r == 1) ? tlen - plen : $urandom_range(tlen - plen);
          for (int unsigned i = 0; i < plen; i++) txt[pos+i] = pat[i];
        end
        if (tlen == 0) begin
          send_beat(sse_pkg::REQ_TEXT, sse_pkg::rune_t'($urandom_range(1114111)), 1'b1, 1'b1);
          sent++;
        end else begin
          foreach (txt[i]) send_beat(sse_pkg::REQ_TEXT, txt[i], 1'b0, i == tlen - 1);
          sent += tlen;
        end
      end else begin
        send_beat(1'($urandom_range(1)), sse_pkg::rune_t'($urandom_range(1114111)),
                  $urandom_range(7) == 0, $urandom_range(3) == 0);
        sent++;
      end
    end
  endtask

  logic [sse_pkg::MODE_W-1:0] phase_mode[8] = '{sse_pkg::MODE_SUFFIX, sse_pkg::MODE_PREFIX,
                                                MODE_UNUSED, sse_pkg::MODE_CONTAINS,
                                                sse_pkg::MODE_PREFIX, sse_pkg::MODE_SUFFIX,
                                                sse_pkg::MODE_CONTAINS, MODE_UNUSED};
  int phase_idle[4] = '{0, 51, 0, 26};
  int phase_stall[4] = '{0, 0, 51, 26};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = sse_pkg::REQ_PATTERN;
    in_tlast = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pattern matches anything at 0
    send_beat(sse_pkg::REQ_PATTERN, '0, 1'b1, 1'b1);
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b0, 1'b1);
    // extreme runes, first index 1
    send_beat(sse_pkg::REQ_PATTERN, RUNE_TOP, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_PATTERN, '0, 1'b0, 1'b1);
    send_beat(sse_pkg::REQ_TEXT, 21'd5, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, RUNE_TOP, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b0, 1'b1);
    // empty text never matches a real pattern
    send_beat(sse_pkg::REQ_TEXT, RUNE_TOP, 1'b1, 1'b1);
    // empty beat inside a text adds nothing
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b1, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, RUNE_TOP, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b0, 1'b1);
    // mode switch in the middle of a text
    send_beat(sse_pkg::REQ_TEXT, RUNE_TOP, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b0, 1'b0);
    write_mode(sse_pkg::MODE_PREFIX);
    send_beat(sse_pkg::REQ_TEXT, 21'd7, 1'b0, 1'b1);
    write_mode(sse_pkg::MODE_SUFFIX);
    send_beat(sse_pkg::REQ_TEXT, 21'd9, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, RUNE_TOP, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_TEXT, '0, 1'b0, 1'b1);
    // new pattern loaded while a text is open
    send_beat(sse_pkg::REQ_TEXT, 21'd1, 1'b0, 1'b0);
    send_beat(sse_pkg::REQ_PATTERN, 21'd3, 1'b0, 1'b1);
    send_beat(sse_pkg::REQ_TEXT, 21'd3, 1'b0, 1'b1);
    write_mode(MODE_UNUSED);
    send_beat(sse_pkg::REQ_TEXT, 21'd3, 1'b0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_mode(phase_mode[p]);
      idle_pct = phase_idle[p % 4];
      stall_pct = phase_stall[p % 4];
      if (p == 0 || p == 4) begin
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      run_random(165);
    end

    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
